FILE: src/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg: shared types, constants and functions
// Chunk ids, kind and status codes, result record, CRC byte step.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam logic [31:0] CRC_POLY   = 32'h1edc6f41;
	localparam logic [31:0] CRC_TOPBIT = 32'h80000000;
	localparam logic [31:0] VERSION_OK = 32'h00040000;

	localparam logic [31:0] ID_FMT  = 32'h50464443;
	localparam logic [31:0] ID_TEXT = 32'h54455854;
	localparam logic [31:0] ID_SECT = 32'h53454354;
	localparam logic [31:0] ID_TAGS = 32'h54414753;
	localparam logic [31:0] ID_DATA = 32'h44415441;
	localparam logic [31:0] ID_END  = 32'h454e4420;

	localparam logic [2:0] KIND_FMT   = 3'd0;
	localparam logic [2:0] KIND_TEXT  = 3'd1;
	localparam logic [2:0] KIND_SECT  = 3'd2;
	localparam logic [2:0] KIND_TAGS  = 3'd3;
	localparam logic [2:0] KIND_DATA  = 3'd4;
	localparam logic [2:0] KIND_END   = 3'd5;
	localparam logic [2:0] KIND_OTHER = 3'd6;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CRC_ERR   = 2'd1;
	localparam logic [1:0] ST_BAD_VER   = 2'd2;
	localparam logic [1:0] ST_TOO_SHORT = 2'd3;

	// header: 8 bytes, crc trailer: 4 bytes, version word: 4 bytes
	localparam logic [31:0] HDR_BYTES = 32'd8;
	localparam logic [31:0] ID_BYTES  = 32'd4;
	localparam logic [31:0] CRC_BYTES = 32'd4;
	localparam logic [31:0] VER_BYTES = 32'd4;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_PAY,
		PH_CRC
	} phase_t;

	typedef struct packed {
		logic [31:0] chunk_id;
		logic [31:0] chunk_length;
		logic [2:0]  chunk_kind;
		logic [1:0]  status;
		logic        stream_end;
	} csc_result_t;

	// MSB-first CRC update by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = {c[31:24] ^ b, 24'd0};
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_TOPBIT) != 32'd0)
				r = (r << 1) ^ CRC_POLY;
			else
				r = r << 1;
		end
		return (c << 8) ^ r;
	endfunction

	function automatic logic [2:0] kind_of(input logic [31:0] id);
		logic [2:0] k;
		unique case (id)
			ID_FMT:  k = KIND_FMT;
			ID_TEXT: k = KIND_TEXT;
			ID_SECT: k = KIND_SECT;
			ID_TAGS: k = KIND_TAGS;
			ID_DATA: k = KIND_DATA;
			ID_END:  k = KIND_END;
			default: k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

FILE: src/csc_if.sv
// ----------------------------------------------------------------------------
// csc_in_if / csc_out_if: stream channels
// Valid/ready channels for stream bytes and per-chunk reports.
// ----------------------------------------------------------------------------
interface csc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface csc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_id;
	logic [31:0] chunk_length;
	logic [2:0]  chunk_kind;
	logic [1:0]  status;
	logic        stream_end;

	modport source (output valid, output chunk_id, output chunk_length, output chunk_kind,
		output status, output stream_end, input ready);
	modport sink   (input valid, input chunk_id, input chunk_length, input chunk_kind,
		input status, input stream_end, output ready);
endinterface

FILE: src/csc_parser.sv
// ----------------------------------------------------------------------------
// csc_parser: input register and chunk parser
// Registers each byte, then walks header, payload and CRC trailer in
// combinational logic, updating parser state, giving at most one report.
// ----------------------------------------------------------------------------
module csc_parser
	import csc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	csc_in_if.sink      in_ch,
	input  logic        res_space,
	output logic        res_valid,
	output csc_result_t res
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       fire;

	phase_t      phase_q;
	logic [31:0] cnt_q, id_q, len_q, crc_q, rcv_q, ver_q;
	logic        first_q, halted_q;

	phase_t      ph, ph_n;
	logic [31:0] cnt, id, len, crc, rcv, ver;
	logic [31:0] cnt_n, id_n, len_n, crc_n, rcv_n, ver_n;
	logic        first, halt, first_n, halt_n;
	logic [31:0] cnt_inc, crc_upd;
	logic        emit, fin;
	logic [1:0]  st;

	assign fire        = v_s1 && res_space;
	assign in_ch.ready = !v_s1 || res_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1    <= in_ch.data_byte;
			restart_s1 <= in_ch.restart;
		end
	end

	always_comb begin
		// a restart byte sees the reset state
		ph    = restart_s1 ? PH_HEAD : phase_q;
		cnt   = restart_s1 ? 32'd0 : cnt_q;
		id    = restart_s1 ? 32'd0 : id_q;
		len   = restart_s1 ? 32'd0 : len_q;
		crc   = restart_s1 ? 32'd0 : crc_q;
		rcv   = restart_s1 ? 32'd0 : rcv_q;
		ver   = restart_s1 ? 32'd0 : ver_q;
		first = restart_s1 ? 1'b1 : first_q;
		halt  = restart_s1 ? 1'b0 : halted_q;

		ph_n    = ph;
		cnt_n   = cnt;
		id_n    = id;
		len_n   = len;
		crc_n   = crc;
		rcv_n   = rcv;
		ver_n   = ver;
		first_n = first;
		emit    = 1'b0;
		fin     = 1'b0;
		st      = ST_OK;

		cnt_inc = cnt + 32'd1;
		crc_upd = crc_byte(crc, byte_s1);

		if (!halt) begin
			unique case (ph)
				PH_PAY: begin
					crc_n = crc_upd;
					if (first && cnt < VER_BYTES)
						ver_n = {ver[23:0], byte_s1};
					cnt_n = cnt_inc;
					if (first && cnt_inc == VER_BYTES && ver_n != VERSION_OK) begin
						emit = 1'b1;
						fin  = 1'b1;
						st   = ST_BAD_VER;
					end else if (cnt_inc == len) begin
						cnt_n = 32'd0;
						ph_n  = PH_CRC;
					end
				end
				PH_CRC: begin
					rcv_n = {rcv[23:0], byte_s1};
					cnt_n = cnt_inc;
					if (cnt_inc >= CRC_BYTES) begin
						emit    = 1'b1;
						st      = (rcv_n == crc) ? ST_OK : ST_CRC_ERR;
						fin     = (rcv_n != crc) || (!first && id == ID_END);
						first_n = 1'b0;
						ph_n    = PH_HEAD;
						cnt_n   = 32'd0;
						crc_n   = 32'd0;
						rcv_n   = 32'd0;
					end
				end
				default: begin
					ph_n  = PH_HEAD;
					crc_n = crc_upd;
					if (cnt < ID_BYTES)
						id_n = {id[23:0], byte_s1};
					else
						len_n = {len[23:0], byte_s1};
					cnt_n = cnt_inc;
					if (cnt_inc >= HDR_BYTES) begin
						cnt_n = 32'd0;
						if (first && len_n < VER_BYTES) begin
							emit = 1'b1;
							fin  = 1'b1;
							st   = ST_TOO_SHORT;
						end else begin
							ph_n = (len_n == 32'd0) ? PH_CRC : PH_PAY;
						end
					end
				end
			endcase
		end
		halt_n = halt || (emit && fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			cnt_q    <= 32'd0;
			id_q     <= 32'd0;
			len_q    <= 32'd0;
			crc_q    <= 32'd0;
			rcv_q    <= 32'd0;
			ver_q    <= 32'd0;
			first_q  <= 1'b1;
			halted_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= ph_n;
			cnt_q    <= cnt_n;
			id_q     <= id_n;
			len_q    <= len_n;
			crc_q    <= crc_n;
			rcv_q    <= rcv_n;
			ver_q    <= ver_n;
			first_q  <= first_n;
			halted_q <= halt_n;
		end
	end

	assign res_valid        = fire && emit;
	assign res.chunk_id     = id_n;
	assign res.chunk_length = len_n;
	assign res.chunk_kind   = kind_of(id_n);
	assign res.status       = st;
	assign res.stream_end   = fin;

endmodule

FILE: src/csc_out_buf.sv
// ----------------------------------------------------------------------------
// csc_out_buf: two-entry report buffer
// Holds finished reports so the parser runs on through sink stalls until full.
// ----------------------------------------------------------------------------
module csc_out_buf
	import csc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  csc_result_t push_data,
	output logic        space,
	csc_out_if.source   out_ch
);

	csc_result_t ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;
	csc_result_t head;

	assign space = (count_q != 2'd2);
	assign pop   = out_ch.valid && out_ch.ready;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	assign out_ch.valid        = (count_q != 2'd0);
	assign out_ch.chunk_id     = head.chunk_id;
	assign out_ch.chunk_length = head.chunk_length;
	assign out_ch.chunk_kind   = head.chunk_kind;
	assign out_ch.status       = head.status;
	assign out_ch.stream_end   = head.stream_end;

endmodule

FILE: src/chunk_stream_crc_checker.sv
// ----------------------------------------------------------------------------
// chunk_stream_crc_checker: chunk container stream checker
// Parses chunk headers, checks the per-chunk CRC and format version.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while the output buffer has space. Each
// request is registered, then combinational logic (header/payload/CRC parsing
// plus an 8-bit CRC-32C update, poly 0x1EDC6F41, MSB first, init 0) updates
// the parser and may produce a report, which lands in a two-entry output
// buffer and is shown on the output from there. Input ready drops only while
// that buffer is full. A byte with restart set clears all parser state before
// it is parsed; after an end chunk that is not the first chunk, or after an
// error, bytes are taken and dropped until a restart.
module chunk_stream_crc_checker
	import csc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	csc_in_if.sink    in_ch,
	csc_out_if.source out_ch
);

	logic        res_valid;
	logic        res_space;
	csc_result_t res;

	csc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_space (res_space),
		.res_valid (res_valid),
		.res       (res)
	);

	csc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (res_space),
		.out_ch    (out_ch)
	);

endmodule
